// ===== rtl/core/clpf_pkg.sv =====
// Shared types and constants of the cache line placement block.
package clpf_pkg;

  localparam int ADDR_W  = 32;
  localparam int LINES   = 64;
  localparam int LINE_W  = 6;
  localparam int OFF_W   = 5;
  localparam int LOG_W   = 3;
  localparam int OUT_W   = 40;
  localparam int PADDR_W = 4;

  // Largest usable log2 of the line count.
  localparam logic [LOG_W-1:0] LINES_LOG2_CAP = 3'd6;

  // Configuration register indexes (word addresses).
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_LINES_LOG2  = 2'd1;
  localparam logic [1:0] REG_WAYS_LOG2   = 2'd2;

  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] addr;
    logic [ADDR_W-1:0] data;
  } blk_wr_t;

  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] addr;
    logic [LINE_W-1:0] data;
  } ptr_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

// ===== rtl/core/cache_line_placement_fifo_core.sv =====
// Top level of the cache line placement block with oldest-first replacement.
//
// Each input beat on the s_ side carries one byte address. The block drops the
// offset bits, selects a set from the low block-address bits and places the
// block in the first invalid way of that set, otherwise in the oldest way.
// One result beat per input beat leaves on the m_ side: the line written,
// whether a valid line was replaced and the replaced block address.
// A beat is accepted while idle, or in the final state of the one before once
// the output register is free. The per-set pointer is read in the accept
// cycle; the following cycle decides the way, reads the old block and writes
// the line and pointer stores back; the final state loads the output register.
// The output register lets the next beat be accepted while a result waits;
// when the receiver stalls, at most one further beat is taken and then
// s_tready stays low until the output register frees.
// Reset (synchronous, active high) clears all line valid bits and set
// pointers and restores the registers to their defaults; no clearing pass.
// The registers sit on the APB port at 0x0, 0x4 and 0x8 and should only be
// written while the block is idle.
module cache_line_placement_fifo_core
  import clpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [ADDR_W-1:0]  s_tdata,   // [31:0] byte_address
  // Result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata    // [5:0] line_index, [6] evicted,
                                        // [38:7] evicted_block, [39] zero
);

  logic [OFF_W-1:0] offset_bits;
  logic [LOG_W-1:0] lines_log2;
  logic [LOG_W-1:0] ways_log2;

  state_t state, state_next;

  logic              s_acc;
  logic              out_free;
  logic [ADDR_W-1:0] in_block;
  logic [LOG_W-1:0]  llog, wlog, sets_log2;
  logic [LINE_W-1:0] set_mask, in_set, in_base, in_way_mask;

  logic [ADDR_W-1:0] block;
  logic [LINE_W-1:0] set_q, base_q, way_mask_q;
  logic [LOG_W-1:0]  wlog_q;

  logic [LINES-1:0]  line_valid;
  logic [LINES-1:0]  window;
  logic [LINES-1:0]  free_ways;
  logic              found;
  logic [LINE_W-1:0] first_free;
  logic [LINE_W-1:0] way, line;
  logic [LINE_W-1:0] ptr_rd;
  logic [ADDR_W-1:0] blk_rd;

  logic [LINE_W-1:0] line_q;
  logic              ev_q;

  blk_wr_t blk_wr;
  ptr_wr_t ptr_wr;
  logic    cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 5'd4;
      lines_log2  <= 3'd6;
      ways_log2   <= 3'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_OFFSET_BITS: offset_bits <= pwdata[OFF_W-1:0];
        REG_LINES_LOG2:  lines_log2  <= pwdata[LOG_W-1:0];
        REG_WAYS_LOG2:   ways_log2   <= pwdata[LOG_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OFFSET_BITS: prdata = {27'd0, offset_bits};
      REG_LINES_LOG2:  prdata = {29'd0, lines_log2};
      REG_WAYS_LOG2:   prdata = {29'd0, ways_log2};
      default:         prdata = '0;
    endcase
  end

  // Geometry of the incoming access.
  always_comb begin
    llog        = (lines_log2 > LINES_LOG2_CAP) ? LINES_LOG2_CAP : lines_log2;
    wlog        = (ways_log2 > llog) ? llog : ways_log2;
    sets_log2   = llog - wlog;
    set_mask    = LINE_W'((7'd1 << sets_log2) - 7'd1);
    in_way_mask = LINE_W'((7'd1 << wlog) - 7'd1);
    in_block    = s_tdata >> offset_bits;
    in_set      = in_block[LINE_W-1:0] & set_mask;
    in_base     = LINE_W'(in_set << wlog);
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) || ((state == ST_FIN) && out_free);
  assign s_acc    = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_acc) state_next = ST_RD;
      ST_RD:   state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = s_acc ? ST_RD : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      block      <= in_block;
      set_q      <= in_set;
      base_q     <= in_base;
      way_mask_q <= in_way_mask;
      wlog_q     <= wlog;
    end
  end

  // First invalid way of the set: the valid bits are aligned to the set base.
  always_comb begin
    window     = line_valid >> base_q;
    free_ways  = ~window & ((LINES'(1) << (LINES'(1) << wlog_q)) - LINES'(1));
    found      = 1'b0;
    first_free = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (free_ways[i]) begin
        found      = 1'b1;
        first_free = LINE_W'(i);
      end
    end
    way  = found ? first_free : (ptr_rd & way_mask_q);
    line = base_q + way;
  end

  always_comb begin
    blk_wr.en   = (state == ST_RD);
    blk_wr.addr = line;
    blk_wr.data = block;
    ptr_wr.en   = (state == ST_RD);
    ptr_wr.addr = set_q;
    ptr_wr.data = (way + LINE_W'(1)) & way_mask_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (state == ST_RD) begin
      line_valid[line] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      line_q <= line;
      ev_q   <= line_valid[line];
    end
  end

  clpf_ptr_store u_ptr_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_acc),
    .rd_addr (in_set),
    .rd_data (ptr_rd),
    .wr      (ptr_wr)
  );

  clpf_block_ram u_block_ram (
    .clk     (clk),
    .rd_en   (state == ST_RD),
    .rd_addr (line),
    .rd_data (blk_rd),
    .wr      (blk_wr)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      m_tdata <= {1'b0, (ev_q ? blk_rd : {ADDR_W{1'b0}}), ev_q, line_q};
    end
  end

endmodule

// ===== rtl/core/clpf_block_ram.sv =====
// Block address store of the cache lines, one synchronous read and one write port.
module clpf_block_ram
  import clpf_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [LINE_W-1:0] rd_addr,
  output logic [ADDR_W-1:0] rd_data,
  input  blk_wr_t           wr
);

  logic [ADDR_W-1:0] mem [LINES];

  // A read and a write to the same entry in one cycle return the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

endmodule

// ===== rtl/core/clpf_ptr_store.sv =====
// Per-set replacement pointer store; entries never written read as zero.
module clpf_ptr_store
  import clpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [LINE_W-1:0] rd_addr,
  output logic [LINE_W-1:0] rd_data,
  input  ptr_wr_t           wr
);

  logic [LINE_W-1:0] mem [LINES];
  logic [LINES-1:0]  written;
  logic [LINE_W-1:0] rd_raw;
  logic              rd_written;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_written ? rd_raw : '0;

endmodule

// ===== tb/tb_cache_line_placement_fifo_core.sv =====
// Self-checking testbench for the cache line placement block with oldest-first replacement.
`timescale 1ns / 100ps

module tb_cache_line_placement_fifo_core;
  import clpf_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_ROWS        = 32;

  // Index 3 has no register behind it; item rows carry it as filler.
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [LINE_W-1:0] line_index;
    logic              evicted;
    logic [ADDR_W-1:0] evicted_block;
  } placement_t;

  typedef enum logic {
    ROW_ACCESS,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        typed;
    placement_t  want;
  } row_t;

  // Accesses under the reset geometry, offset extremes, saturated lines and ways,
  // a single line, an ignored write, then a small two-way and fully associative cache.
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 32'h0}},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0400, 1'b1, '{6'd0, 1'b1, 32'h0}},
    '{ROW_ACCESS, REG_SPARE, 32'hFFFF_FFFF, 1'b1, '{6'd63, 1'b0, 32'h0}},
    '{ROW_ACCESS, REG_SPARE, 32'hFFFF_FFF0, 1'b1, '{6'd63, 1'b1, 32'h0FFF_FFFF}},
    '{ROW_REG, REG_OFFSET_BITS, 32'd0, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'hFFFF_FFFF, 1'b1, '{6'd63, 1'b1, 32'h0FFF_FFFF}},
    '{ROW_ACCESS, REG_SPARE, 32'hFFFF_FFBF, 1'b1, '{6'd63, 1'b1, 32'hFFFF_FFFF}},
    '{ROW_REG, REG_OFFSET_BITS, 32'd31, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h8000_0000, 1'b1, '{6'd1, 1'b0, 32'h0}},
    '{ROW_ACCESS, REG_SPARE, 32'h7FFF_FFFF, 1'b1, '{6'd0, 1'b1, 32'h40}},
    '{ROW_REG, REG_WAYS_LOG2, 32'd7, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'hA5A5_A5A5, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h5A5A_5A5A, 1'b0, '0},
    '{ROW_REG, REG_LINES_LOG2, 32'd7, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0001, 1'b0, '0},
    '{ROW_REG, REG_LINES_LOG2, 32'd0, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h1234_5678, 1'b0, '0},
    '{ROW_REG, REG_SPARE, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_REG, REG_OFFSET_BITS, 32'd4, 1'b0, '0},
    '{ROW_REG, REG_LINES_LOG2, 32'd3, 1'b0, '0},
    '{ROW_REG, REG_WAYS_LOG2, 32'd1, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0040, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0080, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_00C0, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0010, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0100, 1'b0, '0},
    '{ROW_REG, REG_WAYS_LOG2, 32'd3, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_0200, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'h0000_03F0, 1'b0, '0},
    '{ROW_ACCESS, REG_SPARE, 32'hDEAD_BEEF, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [ADDR_W-1:0]  s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;

  // Predictor copy of the registers and the line stores.
  logic [OFF_W-1:0]  cfg_offset;
  logic [LOG_W-1:0]  cfg_lines;
  logic [LOG_W-1:0]  cfg_ways;
  bit                line_valid [LINES];
  logic [ADDR_W-1:0] line_block [LINES];
  logic [LINE_W-1:0] set_ptr [LINES];

  placement_t expected_placements[$];
  placement_t want;
  int         err_count = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;

  cache_line_placement_fifo_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Works out where a block lands and updates the predictor's stores.
  function automatic placement_t place_block(input logic [ADDR_W-1:0] addr);
    placement_t        res;
    logic [ADDR_W-1:0] blk;
    int                llog, wlog, ways, set_idx, base, way, line, i;
    bit                found;
    blk = addr >> cfg_offset;
    llog = (cfg_lines > LINES_LOG2_CAP) ? int'(LINES_LOG2_CAP) : int'(cfg_lines);
    wlog = (int'(cfg_ways) > llog) ? llog : int'(cfg_ways);
    ways = 1 << wlog;
    set_idx = int'(blk & ((32'd1 << (llog - wlog)) - 32'd1));
    base = set_idx << wlog;
    found = 1'b0;
    way = 0;
    for (i = 0; i < ways; i++) begin
      if (!found && !line_valid[(base + i) % LINES]) begin
        way = i;
        found = 1'b1;
      end
    end
    if (!found)
      way = int'(set_ptr[set_idx % LINES]) & (ways - 1);
    line = (base + way) % LINES;
    res.line_index = LINE_W'(line);
    res.evicted = line_valid[line];
    res.evicted_block = line_valid[line] ? line_block[line] : '0;
    line_valid[line] = 1'b1;
    line_block[line] = blk;
    set_ptr[set_idx % LINES] = LINE_W'((way + 1) & (ways - 1));
    return res;
  endfunction

  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_OFFSET_BITS: cfg_offset = value[OFF_W-1:0];
      REG_LINES_LOG2:  cfg_lines = value[LOG_W-1:0];
      REG_WAYS_LOG2:   cfg_ways = value[LOG_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one address beat after a random gap and records what it should produce.
  task automatic issue_address(input logic [ADDR_W-1:0] addr, input int idle_pct,
                               input logic typed, input placement_t typed_want);
    placement_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= addr;
    do @(posedge clk); while (!s_tready);
    predicted = place_block(addr);
    expected_placements.push_back(typed ? typed_want : predicted);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_placements.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_placements.size() == 0) begin
        $error("result beat with no expectation waiting: m_tdata=%h", m_tdata);
        err_count++;
      end else begin
        want = expected_placements.pop_front();
        if (m_tdata[5:0] !== want.line_index) begin
          $error("line_index: expected %0d, got %0d", want.line_index, m_tdata[5:0]);
          err_count++;
        end
        if (m_tdata[6] !== want.evicted) begin
          $error("evicted: expected %0b, got %0b", want.evicted, m_tdata[6]);
          err_count++;
        end
        if (m_tdata[38:7] !== want.evicted_block) begin
          $error("evicted_block: expected %h, got %h", want.evicted_block, m_tdata[38:7]);
          err_count++;
        end
        if (m_tdata[39] !== 1'b0) begin
          $error("pad bit: expected 0, got %b", m_tdata[39]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                idle_pct;
    int                mode;
    logic [ADDR_W-1:0] blk;
    logic [63:0]       wide;
    cfg_offset = 5'd4;
    cfg_lines = 3'd6;
    cfg_ways = 3'd0;
    for (int l = 0; l < LINES; l++) begin
      line_valid[l] = 1'b0;
      line_block[l] = '0;
      set_ptr[l] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIR_ROWS[r].kind == ROW_REG) begin
        drain_results();
        write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].value);
      end else begin
        issue_address(DIR_ROWS[r].value, 0, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      if ($urandom_range(3) == 0)
        write_reg(REG_OFFSET_BITS, $urandom_range(1) ? 32'd31 : 32'd0);
      else
        write_reg(REG_OFFSET_BITS, $urandom_range(10, 2));
      write_reg(REG_LINES_LOG2, $urandom_range(7));
      write_reg(REG_WAYS_LOG2, $urandom_range(7));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Once in the run the sender holds off until every result is back.
        if (ph == 3 && n == ITEMS_PER_PHASE / 2)
          drain_results();
        mode = $urandom_range(99);
        if (mode < 15) begin
          wide = {32'h0, $urandom};
        end else begin
          // A small pool of blocks keeps the sets full, so replacement is exercised.
          blk = $urandom_range(95);
          wide = (64'(blk) << cfg_offset) | (64'($urandom) & ((64'd1 << cfg_offset) - 64'd1));
        end
        issue_address(wide[31:0], idle_pct, 1'b0, '0);
      end
    end

    drain_results();
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== cache_line_placement_fifo_core.f =====
rtl/core/clpf_pkg.sv
rtl/core/clpf_block_ram.sv
rtl/core/clpf_ptr_store.sv
rtl/core/cache_line_placement_fifo_core.sv
tb/tb_cache_line_placement_fifo_core.sv
